@@ hw/rtl/lls_pkg.sv @@
// ============================================================================
// lls_pkg: shared types, codes and tables of the LQR lateral steering unit
// Microcode, register map, opcode set, CORDIC angle table, Q32.32 helpers.
// ============================================================================
package lls_pkg;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_FX = 64'h0000_0001_0000_0000;
	localparam int DIV_STEPS = 96;
	localparam int CW = 36;  // CORDIC x/y width
	localparam int ZW = 34;  // CORDIC angle width, Q4.30
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sh0_6487_ED51;
	localparam int NUM_SLOTS = 5;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// config register indexes
	localparam logic [2:0] CFG_AXLE   = 3'd0;
	localparam logic [2:0] CFG_PERIOD = 3'd1;
	localparam logic [2:0] CFG_FLOOR  = 3'd2;
	localparam logic [2:0] CFG_LATW   = 3'd3;
	localparam logic [2:0] CFG_HEADW  = 3'd4;
	localparam logic [2:0] CFG_STEERW = 3'd5;
	localparam logic [2:0] CFG_FFS    = 3'd6;

	typedef logic [4:0] reg_t;
	typedef logic [6:0] pc_t;

	typedef enum logic [3:0] {
		OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_ABS, OP_NEG, OP_MUL, OP_DIV,
		OP_ATAN, OP_OUT, OP_LOOP, OP_DONE
	} op_t;

	typedef enum logic [3:0] {
		SRC_LAT, SRC_HEAD, SRC_CURV, SRC_VM, SRC_WB, SRC_TP, SRC_Q0, SRC_Q1,
		SRC_R, SRC_FFS, SRC_LRAW, SRC_ZERO
	} src_t;

	typedef enum logic [2:0] {
		C_IDLE, C_READ, C_EXEC, C_WAIT, C_WRITE, C_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		A_IDLE, A_DIV, A_CORD, A_FIN
	} atan_ph_t;

	typedef struct packed {
		op_t  op;
		reg_t dst;
		reg_t a;
		reg_t b;
		src_t src;
	} instr_t;

	typedef struct packed {
		logic cap;
		logic rd;
		logic start;
		logic wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic lt1;
	} sts_t;

	typedef struct packed {
		logic [30:0] axle;
		logic [30:0] period;
		logic [30:0] floor;
		logic [30:0] latw;
		logic [30:0] headw;
		logic [30:0] steerw;
		logic [31:0] ffs;
	} cfg_t;

	// register file map
	localparam reg_t R_LAT  = 5'd0;
	localparam reg_t R_HEAD = 5'd1;
	localparam reg_t R_CURV = 5'd2;
	localparam reg_t R_VM   = 5'd3;
	localparam reg_t R_WB   = 5'd4;
	localparam reg_t R_TP   = 5'd5;
	localparam reg_t R_Q0   = 5'd6;
	localparam reg_t R_Q1   = 5'd7;
	localparam reg_t R_RR   = 5'd8;
	localparam reg_t R_FFS  = 5'd9;
	localparam reg_t R_LRAW = 5'd10;
	localparam reg_t R_A01  = 5'd11;
	localparam reg_t R_B1   = 5'd12;
	localparam reg_t R_P00  = 5'd13;
	localparam reg_t R_P01  = 5'd14;
	localparam reg_t R_P11  = 5'd15;
	localparam reg_t R_PB0  = 5'd16;
	localparam reg_t R_PB1  = 5'd17;
	localparam reg_t R_S    = 5'd18;
	localparam reg_t R_BPA1 = 5'd19;
	localparam reg_t R_K0   = 5'd20;
	localparam reg_t R_K1   = 5'd21;
	localparam reg_t R_T0   = 5'd22;
	localparam reg_t R_T1   = 5'd23;
	localparam reg_t R_T2   = 5'd24;
	localparam reg_t R_N00  = 5'd25;
	localparam reg_t R_N01  = 5'd26;
	localparam reg_t R_N11  = 5'd27;

	// output slots
	localparam reg_t SL_STEER = 5'd0;
	localparam reg_t SL_FB    = 5'd1;
	localparam reg_t SL_FF    = 5'd2;
	localparam reg_t SL_GLAT  = 5'd3;
	localparam reg_t SL_GHEAD = 5'd4;

	localparam pc_t LOOP_START = 7'd16;

	function automatic instr_t mk(op_t op, reg_t dst, reg_t a, reg_t b);
		instr_t r;
		r.op = op;
		r.dst = dst;
		r.a = a;
		r.b = b;
		r.src = SRC_ZERO;
		return r;
	endfunction

	function automatic instr_t ld(reg_t dst, src_t src);
		instr_t r;
		r = mk(OP_LD, dst, R_LAT, R_LAT);
		r.src = src;
		return r;
	endfunction

	function automatic instr_t ucode(pc_t pc);
		instr_t r;
		case (pc)
			7'd0:  r = ld(R_LAT, SRC_LAT);
			7'd1:  r = ld(R_HEAD, SRC_HEAD);
			7'd2:  r = ld(R_CURV, SRC_CURV);
			7'd3:  r = ld(R_VM, SRC_VM);
			7'd4:  r = ld(R_WB, SRC_WB);
			7'd5:  r = ld(R_TP, SRC_TP);
			7'd6:  r = ld(R_Q0, SRC_Q0);
			7'd7:  r = ld(R_Q1, SRC_Q1);
			7'd8:  r = ld(R_RR, SRC_R);
			7'd9:  r = ld(R_FFS, SRC_FFS);
			7'd10: r = ld(R_LRAW, SRC_LRAW);
			7'd11: r = ld(R_P01, SRC_ZERO);
			7'd12: r = ld(R_P00, SRC_Q0);
			7'd13: r = ld(R_P11, SRC_Q1);
			7'd14: r = mk(OP_MUL, R_A01, R_TP, R_VM);
			7'd15: r = mk(OP_DIV, R_B1, R_A01, R_WB);
			// Riccati round
			7'd16: r = mk(OP_MUL, R_PB0, R_B1, R_P01);
			7'd17: r = mk(OP_MUL, R_PB1, R_B1, R_P11);
			7'd18: r = mk(OP_MUL, R_T0, R_B1, R_PB1);
			7'd19: r = mk(OP_ADD, R_S, R_RR, R_T0);
			7'd20: r = mk(OP_MUL, R_T0, R_PB0, R_A01);
			7'd21: r = mk(OP_ADD, R_BPA1, R_T0, R_PB1);
			7'd22: r = mk(OP_DIV, R_K0, R_PB0, R_S);
			7'd23: r = mk(OP_DIV, R_K1, R_BPA1, R_S);
			7'd24: r = mk(OP_MUL, R_T0, R_P00, R_A01);
			7'd25: r = mk(OP_ADD, R_T1, R_T0, R_P01);
			7'd26: r = mk(OP_MUL, R_T2, R_P01, R_A01);
			7'd27: r = mk(OP_MUL, R_T0, R_T0, R_A01);
			7'd28: r = mk(OP_ADD, R_T2, R_T2, R_T2);
			7'd29: r = mk(OP_ADD, R_T0, R_T0, R_T2);
			7'd30: r = mk(OP_ADD, R_T2, R_T0, R_P11);
			7'd31: r = mk(OP_MUL, R_T0, R_PB0, R_K0);
			7'd32: r = mk(OP_ADD, R_N00, R_Q0, R_P00);
			7'd33: r = mk(OP_SUB, R_N00, R_N00, R_T0);
			7'd34: r = mk(OP_MUL, R_T0, R_PB0, R_K1);
			7'd35: r = mk(OP_SUB, R_N01, R_T1, R_T0);
			7'd36: r = mk(OP_MUL, R_T0, R_BPA1, R_K1);
			7'd37: r = mk(OP_ADD, R_N11, R_Q1, R_T2);
			7'd38: r = mk(OP_SUB, R_N11, R_N11, R_T0);
			7'd39: r = mk(OP_SUB, R_T0, R_N00, R_P00);
			7'd40: r = mk(OP_ABS, R_T0, R_T0, R_T0);
			7'd41: r = mk(OP_SUB, R_T1, R_N01, R_P01);
			7'd42: r = mk(OP_ABS, R_T1, R_T1, R_T1);
			7'd43: r = mk(OP_ADD, R_T0, R_T0, R_T1);
			7'd44: r = mk(OP_SUB, R_T1, R_N11, R_P11);
			7'd45: r = mk(OP_ABS, R_T1, R_T1, R_T1);
			7'd46: r = mk(OP_ADD, R_T0, R_T0, R_T1);
			7'd47: r = mk(OP_MOV, R_P00, R_N00, R_N00);
			7'd48: r = mk(OP_MOV, R_P01, R_N01, R_N01);
			7'd49: r = mk(OP_MOV, R_P11, R_N11, R_N11);
			7'd50: r = mk(OP_LOOP, R_LAT, R_LAT, R_LAT);
			// gains and steering
			7'd51: r = mk(OP_MUL, R_PB0, R_B1, R_P01);
			7'd52: r = mk(OP_MUL, R_PB1, R_B1, R_P11);
			7'd53: r = mk(OP_MUL, R_T0, R_B1, R_PB1);
			7'd54: r = mk(OP_ADD, R_S, R_RR, R_T0);
			7'd55: r = mk(OP_DIV, R_K0, R_PB0, R_S);
			7'd56: r = mk(OP_MUL, R_T0, R_PB0, R_A01);
			7'd57: r = mk(OP_ADD, R_T0, R_T0, R_PB1);
			7'd58: r = mk(OP_DIV, R_K1, R_T0, R_S);
			7'd59: r = mk(OP_MUL, R_T0, R_K0, R_LAT);
			7'd60: r = mk(OP_MUL, R_T1, R_K1, R_HEAD);
			7'd61: r = mk(OP_ADD, R_T0, R_T0, R_T1);
			7'd62: r = mk(OP_NEG, R_T0, R_T0, R_T0);
			7'd63: r = mk(OP_MUL, R_T1, R_LRAW, R_CURV);
			7'd64: r = mk(OP_ATAN, R_T1, R_T1, R_T1);
			7'd65: r = mk(OP_MUL, R_T1, R_FFS, R_T1);
			7'd66: r = mk(OP_ADD, R_T2, R_T0, R_T1);
			7'd67: r = mk(OP_OUT, SL_STEER, R_T2, R_T2);
			7'd68: r = mk(OP_OUT, SL_FB, R_T0, R_T0);
			7'd69: r = mk(OP_OUT, SL_FF, R_T1, R_T1);
			7'd70: r = mk(OP_OUT, SL_GLAT, R_K0, R_K0);
			7'd71: r = mk(OP_OUT, SL_GHEAD, R_K1, R_K1);
			default: r = mk(OP_DONE, R_LAT, R_LAT, R_LAT);
		endcase
		return r;
	endfunction

	function automatic logic [63:0] mag_of(logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
		logic signed [63:0] c;
		c = m[63] ? SAT_MAX : $signed(m);
		return neg ? -c : c;
	endfunction

	function automatic logic signed [63:0] sat65(logic signed [64:0] v);
		logic signed [63:0] r;
		if (v > 65'(SAT_MAX))
			r = SAT_MAX;
		else if (v < -65'(SAT_MAX))
			r = -SAT_MAX;
		else
			r = v[63:0];
		return r;
	endfunction

endpackage

@@ hw/rtl/lls_mul.sv @@
// ============================================================================
// lls_mul: Q32.32 saturating multiplier
// Sign-magnitude product built from four 32x32 partial products.
// ============================================================================
module lls_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [63:0]       a,
	input  logic signed [63:0]       b,
	output logic                     busy,
	output logic signed [63:0]       p
);
	import lls_pkg::*;

	logic        busy_q;
	logic [2:0]  cnt_q;
	logic [63:0] ma_q, mb_q;
	logic        neg_q;
	logic [63:0] pp_q;
	logic [1:0]  ppsh_q;
	logic [127:0] acc_q;
	logic signed [63:0] p_q;
	logic [31:0] opx, opy;
	logic [1:0]  sh;
	logic [127:0] pp_ext;
	logic [63:0] mag;

	always_comb begin
		case (cnt_q)
			3'd0: begin opx = ma_q[31:0];  opy = mb_q[31:0];  sh = 2'd0; end
			3'd1: begin opx = ma_q[31:0];  opy = mb_q[63:32]; sh = 2'd1; end
			3'd2: begin opx = ma_q[63:32]; opy = mb_q[31:0];  sh = 2'd1; end
			default: begin opx = ma_q[63:32]; opy = mb_q[63:32]; sh = 2'd2; end
		endcase
		case (ppsh_q)
			2'd0: pp_ext = {64'd0, pp_q};
			2'd1: pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
		mag = (acc_q[127:96] != 32'd0) ? '1 : acc_q[95:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd5)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= mag_of(a);
			mb_q <= mag_of(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				pp_q <= opx * opy;
				ppsh_q <= sh;
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp_ext;
			if (cnt_q == 3'd5)
				p_q <= from_mag(neg_q, mag);
		end
	end

	assign busy = busy_q;
	assign p = p_q;

endmodule

@@ hw/rtl/lls_div.sv @@
// ============================================================================
// lls_div: Q32.32 saturating divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module lls_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [63:0]       n,
	input  logic signed [63:0]       d,
	output logic                     busy,
	output logic signed [63:0]       q
);
	import lls_pkg::*;

	localparam int CNTW = $clog2(DIV_STEPS);

	logic            busy_q, fin_q;
	logic [CNTW-1:0] cnt_q;
	logic [95:0]     num_q;
	logic [63:0]     rem_q, quo_q, md_q;
	logic            neg_q, over_q, zn_q, zd_q;
	logic signed [63:0] q_q;
	logic [63:0]     mn, md;
	logic [64:0]     r65, r65s;
	logic            ge;

	always_comb begin
		mn = mag_of(n);
		md = mag_of(d);
		r65 = {rem_q, num_q[95]};
		ge = r65 >= {1'b0, md_q};
		r65s = r65 - {1'b0, md_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q <= (mn == 64'd0) || (md == 64'd0);
			cnt_q <= '0;
		end else if (fin_q) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(DIV_STEPS - 1))
				fin_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mn, 32'd0};
			md_q <= md;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= n[63] ^ d[63];
			over_q <= 1'b0;
			zn_q <= (mn == 64'd0);
			zd_q <= (md == 64'd0);
		end else if (fin_q) begin
			if (zn_q)
				q_q <= '0;
			else if (zd_q || over_q)
				q_q <= from_mag(neg_q, '1);
			else
				q_q <= from_mag(neg_q, quo_q);
		end else if (busy_q) begin
			num_q <= {num_q[94:0], 1'b0};
			rem_q <= ge ? r65s[63:0] : r65[63:0];
			quo_q <= {quo_q[62:0], ge};
			// bits above the 64-bit quotient mean overflow
			if (ge && cnt_q < CNTW'(32))
				over_q <= 1'b1;
		end
	end

	assign busy = busy_q;
	assign q = q_q;

endmodule

@@ hw/rtl/lls_dpath.sv @@
// ============================================================================
// lls_dpath: datapath of the LQR lateral steering unit
// Register file, saturating ALU, multiplier, divider, CORDIC arctangent,
// operand loads and output slots.
// ============================================================================
module lls_dpath #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lls_pkg::cmd_t   cmd,
	input  lls_pkg::instr_t instr,
	input  lls_pkg::cfg_t   cfg,
	input  logic [127:0]    in_word,
	output lls_pkg::sts_t   sts,
	output logic [159:0]    out_word
);
	import lls_pkg::*;

	localparam int SHIFT_UP = 32 - FRAC_BITS;
	localparam logic signed [CW-1:0] CX_ONE = CW'(ONE_FX);

	logic [31:0] lat_q, head_q, curv_q, spd_q;
	logic signed [63:0] rf_mem [32];
	logic signed [63:0] opa_q, opb_q, alu_q, wval, ldval, alu_val;
	logic        flag_q;
	logic [31:0] slot_q [NUM_SLOTS];
	logic        wr_en;

	logic        mul_busy, div_busy, div_start;
	logic signed [63:0] mul_p, div_q, div_n, div_d;

	atan_ph_t    ph_q, ph_nx;
	logic signed [CW-1:0] cx_q, cy_q, dx, dy;
	logic signed [ZW-1:0] z_q, ang, zf;
	logic [4:0]  i_q;
	logic        big_q, neg_q, atan_go, atan_div_go, a_big;
	logic [63:0] a_mag;
	logic signed [63:0] atan_q, z4;

	logic [32:0] spd_mag, vm_raw;

	function automatic logic signed [63:0] fix32(logic [31:0] x);
		return $signed({{32{x[31]}}, x}) <<< SHIFT_UP;
	endfunction

	function automatic logic signed [63:0] floor1(logic [30:0] v);
		return fix32({1'b0, (v == 31'd0) ? 31'd1 : v});
	endfunction

	function automatic logic [31:0] outq(logic signed [63:0] v);
		logic [63:0] m;
		m = mag_of(v) >> SHIFT_UP;
		if (v[63]) begin
			if (m > 64'h8000_0000)
				m = 64'h8000_0000;
			return 32'd0 - m[31:0];
		end
		if (m > 64'h7FFF_FFFF)
			m = 64'h7FFF_FFFF;
		return m[31:0];
	endfunction

	// operand loads
	always_comb begin
		spd_mag = spd_q[31] ? (33'd0 - {1'b1, spd_q}) : {1'b0, spd_q};
		vm_raw = (spd_mag > {2'b00, cfg.floor}) ? spd_mag : {2'b00, cfg.floor};
		case (instr.src)
			SRC_LAT:  ldval = fix32(lat_q);
			SRC_HEAD: ldval = fix32(head_q);
			SRC_CURV: ldval = fix32(curv_q);
			SRC_VM:   ldval = $signed(64'(vm_raw) << SHIFT_UP);
			SRC_WB:   ldval = floor1(cfg.axle);
			SRC_TP:   ldval = floor1(cfg.period);
			SRC_Q0:   ldval = floor1(cfg.latw);
			SRC_Q1:   ldval = floor1(cfg.headw);
			SRC_R:    ldval = floor1(cfg.steerw);
			SRC_FFS:  ldval = fix32(cfg.ffs);
			SRC_LRAW: ldval = fix32({1'b0, cfg.axle});
			default:  ldval = '0;
		endcase
	end

	always_comb begin
		case (instr.op)
			OP_LD:   alu_val = ldval;
			OP_ADD:  alu_val = sat65(65'(opa_q) + 65'(opb_q));
			OP_SUB:  alu_val = sat65(65'(opa_q) - 65'(opb_q));
			OP_ABS:  alu_val = opa_q[63] ? -opa_q : opa_q;
			OP_NEG:  alu_val = -opa_q;
			default: alu_val = opa_q;
		endcase
		case (instr.op)
			OP_MUL:  wval = mul_p;
			OP_DIV:  wval = div_q;
			OP_ATAN: wval = atan_q;
			default: wval = alu_q;
		endcase
		wr_en = cmd.wr && (instr.op != OP_OUT) && (instr.op != OP_LOOP)
			&& (instr.op != OP_DONE);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			lat_q <= in_word[31:0];
			head_q <= in_word[63:32];
			curv_q <= in_word[95:64];
			spd_q <= in_word[127:96];
		end
		if (cmd.rd) begin
			opa_q <= rf_mem[instr.a];
			opb_q <= rf_mem[instr.b];
		end
		if (cmd.start)
			alu_q <= alu_val;
		if (wr_en)
			rf_mem[instr.dst] <= wval;
		if (cmd.wr && instr.op == OP_OUT) begin
			case (instr.dst)
				SL_STEER: slot_q[0] <= outq(opa_q);
				SL_FB:    slot_q[1] <= outq(opa_q);
				SL_FF:    slot_q[2] <= outq(opa_q);
				SL_GLAT:  slot_q[3] <= outq(opa_q);
				SL_GHEAD: slot_q[4] <= outq(opa_q);
				default:  ;
			endcase
		end
	end

	// early-exit flag follows the last saturating add/sub
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flag_q <= 1'b0;
		else if (cmd.wr && (instr.op == OP_ADD || instr.op == OP_SUB))
			flag_q <= wval < 64'sd1;
	end

	lls_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && instr.op == OP_MUL),
		.a      (opa_q),
		.b      (opb_q),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	// arctangent: |x| > 1 goes through 1/|x| on the shared divider first
	always_comb begin
		atan_go = cmd.start && instr.op == OP_ATAN;
		a_mag = mag_of(opa_q);
		a_big = a_mag > ONE_FX;
		atan_div_go = atan_go && a_big;
		div_start = (cmd.start && instr.op == OP_DIV) || atan_div_go;
		div_n = atan_div_go ? $signed(ONE_FX) : opa_q;
		div_d = atan_div_go ? $signed(a_mag) : opb_q;
		dx = cy_q >>> i_q;
		dy = cx_q >>> i_q;
		ang = ZW'(ATAN_TAB[i_q]);
		zf = big_q ? (HALF_PI_Q30 - z_q) : z_q;
		z4 = 64'(zf) <<< 2;
		ph_nx = ph_q;
		case (ph_q)
			A_IDLE:  if (atan_go) ph_nx = a_big ? A_DIV : A_CORD;
			A_DIV:   if (!div_busy) ph_nx = A_CORD;
			A_CORD:  if (i_q == 5'd31) ph_nx = A_FIN;
			A_FIN:   ph_nx = A_IDLE;
			default: ph_nx = A_IDLE;
		endcase
	end

	lls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.busy   (div_busy),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ph_q <= A_IDLE;
		else
			ph_q <= ph_nx;
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			A_IDLE: begin
				if (atan_go) begin
					big_q <= a_big;
					neg_q <= opa_q[63];
					cx_q <= CX_ONE;
					cy_q <= CW'(a_mag);
					z_q <= '0;
					i_q <= '0;
				end
			end
			A_DIV: begin
				if (!div_busy)
					cy_q <= CW'(div_q);
			end
			A_CORD: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q <= z_q + ang;
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q <= z_q - ang;
				end
				i_q <= i_q + 5'd1;
			end
			default: atan_q <= neg_q ? -z4 : z4;
		endcase
	end

	assign sts.busy = mul_busy || div_busy || (ph_q != A_IDLE);
	assign sts.lt1 = flag_q;
	assign out_word = {slot_q[4], slot_q[3], slot_q[2], slot_q[1], slot_q[0]};

endmodule

@@ hw/rtl/lls_ctrl.sv @@
// ============================================================================
// lls_ctrl: sequencer of the LQR lateral steering unit
// Steps the microcode, counts Riccati rounds, hands results to the output.
// ============================================================================
module lls_ctrl #(
	parameter int MAX_ROUNDS = 200
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            out_free,
	input  lls_pkg::sts_t   sts,
	output lls_pkg::cmd_t   cmd,
	output lls_pkg::instr_t instr
);
	import lls_pkg::*;

	localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

	ctrl_state_t   state_q, state_nx;
	pc_t           pc_q, pc_nx;
	logic [RW-1:0] round_q, round_nx;

	assign instr = ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pc_q <= '0;
			round_q <= '0;
		end else begin
			state_q <= state_nx;
			pc_q <= pc_nx;
			round_q <= round_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		pc_nx = pc_q;
		round_nx = round_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					pc_nx = '0;
					round_nx = '0;
					state_nx = C_READ;
				end
			end
			C_READ: begin
				case (instr.op)
					OP_LOOP: begin
						if (sts.lt1 || round_q == RW'(MAX_ROUNDS - 1)) begin
							pc_nx = pc_q + 7'd1;
						end else begin
							pc_nx = LOOP_START;
							round_nx = round_q + 1'b1;
						end
					end
					OP_DONE: state_nx = C_FINISH;
					default: begin
						cmd.rd = 1'b1;
						state_nx = C_EXEC;
					end
				endcase
			end
			C_EXEC: begin
				cmd.start = 1'b1;
				state_nx = C_WAIT;
			end
			C_WAIT: begin
				if (!sts.busy)
					state_nx = C_WRITE;
			end
			C_WRITE: begin
				cmd.wr = 1'b1;
				pc_nx = pc_q + 7'd1;
				state_nx = C_READ;
			end
			C_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx = C_IDLE;
				end
			end
			default: state_nx = C_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/lqr_lateral_steering_unit.sv @@
// ============================================================================
// lqr_lateral_steering_unit: discrete LQR lateral steering controller
// Per item: builds the two-state lateral model, iterates the Riccati
// recursion, forms the gains, state feedback and arctangent feedforward.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: lat_err, head_err, path_curv,
//          |     |                    |          veh_speed (32b each)
//  m_      | out | m_tvalid/m_tready  | m_tdata: steer_cmd, fb_term, ff_term,
//          |     |                    |          gain_lat, gain_head (32b each)
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item at a time. Setup, the Riccati rounds and the gain/steering tail
//  run in turn, so the time an item takes grows with the number of rounds.
//  The 1-bit-per-cycle divider, used twice per Riccati round, dominates.
//  Reset clears config to defaults and the sequencer to idle; no clearing pass.
//  s_tready is high only while idle; a finished result waits in the output
//  register and the next item is taken meanwhile.
//
module lqr_lateral_steering_unit #(
	parameter int MAX_ROUNDS = 200,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] lat_err, [63:32] head_err, [95:64] path_curv, [127:96] veh_speed
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] steer_cmd, [63:32] fb_term, [95:64] ff_term,
	// [127:96] gain_lat, [159:128] gain_head
	output logic [159:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import lls_pkg::*;

	cfg_t   cfg_q;
	cmd_t   cmd;
	sts_t   sts;
	instr_t instr;
	logic [159:0] out_word;
	logic   out_free;

	// Config registers, always ready; change them only while no item is in
	// flight. Unused index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axle <= 31'd21627;
			cfg_q.period <= 31'd1311;
			cfg_q.floor <= 31'd32768;
			cfg_q.latw <= 31'd65536;
			cfg_q.headw <= 31'd65536;
			cfg_q.steerw <= 31'd65536;
			cfg_q.ffs <= 32'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AXLE:   cfg_q.axle <= cfg_data[30:0];
				CFG_PERIOD: cfg_q.period <= cfg_data[30:0];
				CFG_FLOOR:  cfg_q.floor <= cfg_data[30:0];
				CFG_LATW:   cfg_q.latw <= cfg_data[30:0];
				CFG_HEADW:  cfg_q.headw <= cfg_data[30:0];
				CFG_STEERW: cfg_q.steerw <= cfg_data[30:0];
				CFG_FFS:    cfg_q.ffs <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Output register: free when empty or being drained this cycle.
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.load_out)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			m_tdata <= out_word;
	end

	lls_ctrl #(
		.MAX_ROUNDS (MAX_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.instr    (instr)
	);

	lls_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.instr    (instr),
		.cfg      (cfg_q),
		.in_word  (s_tdata),
		.sts      (sts),
		.out_word (out_word)
	);

endmodule
